@@ src/ccbs_pkg.sv @@
// shared types and constants for the colour contrast blob selector
package ccbs_pkg;

  // field widths
  localparam int LVL_W      = 8;   // colour level
  localparam int Q_FRAC     = 16;  // Q16 fraction bits
  localparam int NRM_W      = 17;  // normalized level, up to 1.0 plus epsilon
  localparam int RAT_W      = 26;  // one target/other ratio
  localparam int SUM_W      = 27;  // sum of two ratios, also the threshold
  localparam int IDX_W      = 8;   // reported blob index

  // serial divider sizing
  localparam int DIVD_W     = NRM_W + Q_FRAC;  // dividend and quotient
  localparam int DIVS_W     = NRM_W;           // divisor and remainder
  localparam int STEP_W     = $clog2(DIVD_W + 1);
  localparam logic [STEP_W-1:0] NORM_STEPS  = STEP_W'(LVL_W + Q_FRAC);
  localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(DIVD_W);

  // normalized levels of the darkest and brightest channel
  localparam logic [NRM_W-1:0] ADD_EPS  = NRM_W'(66);
  localparam logic [NRM_W-1:0] NORM_TOP = NRM_W'(65536 + 66);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SUM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

  // target channel codes
  localparam logic [1:0] TGT_RED   = 2'd0;
  localparam logic [1:0] TGT_GREEN = 2'd1;
  localparam logic [1:0] TGT_BLUE  = 2'd2;
  localparam logic [1:0] TGT_NONE  = 2'd3;

  localparam logic [1:0]       TGT_RESET    = TGT_BLUE;
  localparam logic [SUM_W-1:0] THRESH_RESET = SUM_W'(68813);

  localparam int unsigned MAX_BLOBS_DEF = 256;

  // request to the serial divider
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

@@ src/ccbs_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module ccbs_div
  import ccbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // one trial subtraction per cycle
  assign rem_sh = {rem_r, q_r[DIVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = !diff[DIVS_W];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == STEP_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  // datapath: dividend shifts out on top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVD_W-2:0], ge};
      rem_r <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start && (req.steps != '0) |=> busy_r)
    else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished division");

endmodule

@@ src/colour_contrast_blob_select.sv @@
// colour contrast blob selector top level
// processing: the next item waits until this one is done; there is no middle-level
//   division when no channel lies strictly between the others and none at all for a grey
//   blob, a blob past capacity or target code 3; a last blob also waits while the previous
//   result is stalled; one item at a time, set by the one-bit-per-cycle divider (24 steps
//   for the middle level, 33 for each of two ratios); results wait in an output register
// reset (synchronous, active low) clears the list state and loads register defaults
module colour_contrast_blob_select
  import ccbs_pkg::*;
#(
  parameter int unsigned MAX_BLOBS = MAX_BLOBS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LVL_W-1:0]      in_red_level,
  input  logic [LVL_W-1:0]      in_green_level,
  input  logic [LVL_W-1:0]      in_blue_level,
  input  logic                  in_last_blob,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_best_index,
  output logic [SUM_W-1:0]      out_best_contrast,
  output logic                  out_overflow
);

  localparam int CW = $clog2(MAX_BLOBS + 1);
  localparam int PW = $clog2(MAX_BLOBS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PREP    = 9'b000000010,
    S_NORM    = 9'b000000100,
    S_RA_GO   = 9'b000001000,
    S_RA_WAIT = 9'b000010000,
    S_RB_GO   = 9'b000100000,
    S_RB_WAIT = 9'b001000000,
    S_UPD     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;

  logic [1:0]        tgt_r;
  logic [SUM_W-1:0]  thr_r;

  logic [LVL_W-1:0]  red_r, green_r, blue_r;
  logic              last_r;
  logic [NRM_W-1:0]  nr_r, ng_r, nb_r;
  logic [2:0]        mid_sel_r;
  logic [RAT_W-1:0]  ra_r, rb_r;
  logic [PW-1:0]     pos_r;

  logic [CW-1:0]     cnt_r;
  logic [SUM_W-1:0]  best_r;
  logic [PW-1:0]     best_pos_r;
  logic              have_r;
  logic              ovf_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_ovf_r;

  logic              in_acc;
  logic [LVL_W-1:0]  lo, hi, span, mid_val;
  logic [2:0]        mid_sel;
  logic              grey, no_tgt, ovf_now, skip;
  logic [NRM_W-1:0]  t_n, o1_n, o2_n;
  logic [SUM_W-1:0]  sum;
  logic              qualify;
  logic              out_blocked;
  logic [PW+IDX_W-1:0] pos_ext;

  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;

  // fixed levels: darkest channel, brightest channel, middle filled in later
  function automatic logic [NRM_W-1:0] edge_level(input logic [LVL_W-1:0] x,
                                                  input logic [LVL_W-1:0] l,
                                                  input logic [LVL_W-1:0] h);
    logic [NRM_W-1:0] v;
    if (x == l) v = ADD_EPS;
    else if (x == h) v = NORM_TOP;
    else v = '0;
    return v;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // min, max and middle channel of the held blob
  always_comb begin
    lo = red_r;
    hi = red_r;
    if (green_r < lo) lo = green_r;
    if (blue_r < lo)  lo = blue_r;
    if (green_r > hi) hi = green_r;
    if (blue_r > hi)  hi = blue_r;
  end

  assign span       = hi - lo;
  assign grey       = (hi == lo);
  assign mid_sel[0] = (red_r != lo) && (red_r != hi);
  assign mid_sel[1] = (green_r != lo) && (green_r != hi);
  assign mid_sel[2] = (blue_r != lo) && (blue_r != hi);
  assign mid_val    = mid_sel[1] ? green_r : (mid_sel[2] ? blue_r : red_r);
  assign no_tgt     = (tgt_r == TGT_NONE);
  assign ovf_now    = (cnt_r >= CW'(MAX_BLOBS));
  assign skip       = ovf_now || grey || no_tgt;

  // target first, then the two other channels
  always_comb begin
    case (tgt_r)
      TGT_RED: begin
        t_n = nr_r; o1_n = ng_r; o2_n = nb_r;
      end
      TGT_GREEN: begin
        t_n = ng_r; o1_n = nr_r; o2_n = nb_r;
      end
      default: begin
        t_n = nb_r; o1_n = ng_r; o2_n = nr_r;
      end
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {t_n, {Q_FRAC{1'b0}}};
    div_req.divisor  = o1_n;
    div_req.steps    = RATIO_STEPS;
    case (state_r)
      S_PREP: begin
        div_req.start    = !skip && (mid_sel != 3'b000);
        div_req.dividend = {mid_val - lo, {(DIVD_W-LVL_W){1'b0}}};
        div_req.divisor  = {{(DIVS_W-LVL_W){1'b0}}, span};
        div_req.steps    = NORM_STEPS;
      end
      S_RA_GO: begin
        div_req.start = 1'b1;
      end
      S_RB_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = o2_n;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ccbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // contrast test and ratio sum
  assign sum         = {1'b0, ra_r} + {1'b0, rb_r};
  assign qualify     = ({1'b0, ra_r} > thr_r) && ({1'b0, rb_r} > thr_r);
  assign out_blocked = out_valid_r && out_stall;
  assign pos_ext     = {{IDX_W{1'b0}}, best_pos_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (skip) state_nxt = S_DONE;
        else if (mid_sel != 3'b000) state_nxt = S_NORM;
        else state_nxt = S_RA_GO;
      end
      S_NORM: begin
        if (div_done) state_nxt = S_RA_GO;
      end
      S_RA_GO: begin
        state_nxt = S_RA_WAIT;
      end
      S_RA_WAIT: begin
        if (div_done) state_nxt = S_RB_GO;
      end
      S_RB_GO: begin
        state_nxt = S_RB_WAIT;
      end
      S_RB_WAIT: begin
        if (div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!last_r || !out_blocked) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state, configuration and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_r       <= TGT_RESET;
      thr_r       <= THRESH_RESET;
      cnt_r       <= '0;
      best_r      <= '0;
      best_pos_r  <= '0;
      have_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_TARGET) tgt_r <= cfg_data[1:0];
        if (cfg_index == CFG_THRESH) thr_r <= cfg_data[SUM_W-1:0];
      end

      // blob position, saturating at capacity
      if (state_r == S_PREP) begin
        if (ovf_now) ovf_r <= 1'b1;
        else cnt_r <= cnt_r + 1'b1;
      end

      // keep the best qualifying blob, earlier wins on ties
      if ((state_r == S_UPD) && qualify && (!have_r || (sum > best_r))) begin
        have_r     <= 1'b1;
        best_r     <= sum;
        best_pos_r <= pos_r;
      end

      // result valid: set on the last blob, dropped once taken
      if ((state_r == S_DONE) && last_r && !out_blocked) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // clear the list after its report
      if ((state_r == S_DONE) && last_r && !out_blocked) begin
        cnt_r       <= '0;
        best_r      <= '0;
        best_pos_r  <= '0;
        have_r      <= 1'b0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      red_r   <= in_red_level;
      green_r <= in_green_level;
      blue_r  <= in_blue_level;
      last_r  <= in_last_blob;
    end
    if (state_r == S_PREP) begin
      nr_r      <= edge_level(red_r, lo, hi);
      ng_r      <= edge_level(green_r, lo, hi);
      nb_r      <= edge_level(blue_r, lo, hi);
      mid_sel_r <= mid_sel;
      pos_r     <= cnt_r[PW-1:0];
    end
    if ((state_r == S_NORM) && div_done) begin
      if (mid_sel_r[0]) nr_r <= div_q[NRM_W-1:0] + ADD_EPS;
      if (mid_sel_r[1]) ng_r <= div_q[NRM_W-1:0] + ADD_EPS;
      if (mid_sel_r[2]) nb_r <= div_q[NRM_W-1:0] + ADD_EPS;
    end
    if ((state_r == S_RA_WAIT) && div_done) ra_r <= div_q[RAT_W-1:0];
    if ((state_r == S_RB_WAIT) && div_done) rb_r <= div_q[RAT_W-1:0];
    if ((state_r == S_DONE) && last_r && !out_blocked) begin
      out_found_r <= have_r;
      out_idx_r   <= have_r ? pos_ext[IDX_W-1:0] : '0;
      out_sum_r   <= have_r ? best_r : '0;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_index    = out_idx_r;
  assign out_best_contrast = out_sum_r;
  assign out_overflow      = out_ovf_r;

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_PREP)
    else $error("accepted item not processed");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE) && $past(last_r))
    else $error("result without a last blob");

  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_idx_r == '0 && out_sum_r == '0)
    else $error("empty result carries a blob");

  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !have_r |-> best_r == '0 && best_pos_r == '0)
    else $error("best kept without a match");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BLOBS))
    else $error("blob counter past capacity");

endmodule
